// ===== sv/rax_pkg.sv =====
`timescale 1ns / 1ps
package rax_pkg;

  localparam int unsigned DIGITS   = 6;
  localparam int unsigned DIGIT_W  = 10;
  localparam int unsigned FIELD_W  = 60;
  localparam int unsigned RADIX    = 1000;
  localparam int unsigned DIGIT_MAX = 999;

  // Carry between digits is -2..+2, held as an offset code 0..4.
  localparam int unsigned NCARRY   = 5;
  localparam int unsigned CARRY_W  = $clog2(NCARRY);
  localparam int unsigned NORM_W   = 13;

  typedef logic [CARRY_W-1:0] carry_t;
  localparam carry_t CARRY_ZERO = carry_t'(2);

  // Bias puts digit value plus incoming carry into a non-negative range.
  localparam logic [NORM_W-1:0] NORM_BIAS = NORM_W'(2 * RADIX - 2);

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    carry_t             cout;
  } cand_t;

  // One candidate per incoming carry code, for each of the three chains.
  typedef struct packed {
    cand_t [NCARRY-1:0] add_c;
    cand_t [NCARRY-1:0] ab_c;
    cand_t [NCARRY-1:0] ba_c;
  } lane_cand_t;

  typedef struct packed {
    logic sa;
    logic sb;
    logic az;
    logic bz;
  } sel_t;

  typedef struct packed {
    logic [FIELD_W-1:0] digits;
    logic               neg;
    logic               zero;
    logic               ovf;
  } res_t;

  // y is the digit value plus carry, biased by 2*RADIX.
  function automatic cand_t digit_norm(logic [NORM_W-1:0] y);
    cand_t              c;
    logic [NORM_W-1:0]  rem;
    begin
      priority if (y >= NORM_W'(4 * RADIX)) begin
        c.cout = carry_t'(4);
        rem    = y - NORM_W'(4 * RADIX);
      end else if (y >= NORM_W'(3 * RADIX)) begin
        c.cout = carry_t'(3);
        rem    = y - NORM_W'(3 * RADIX);
      end else if (y >= NORM_W'(2 * RADIX)) begin
        c.cout = carry_t'(2);
        rem    = y - NORM_W'(2 * RADIX);
      end else if (y >= NORM_W'(RADIX)) begin
        c.cout = carry_t'(1);
        rem    = y - NORM_W'(RADIX);
      end else begin
        c.cout = carry_t'(0);
        rem    = y;
      end
      c.digit = rem[DIGIT_W-1:0];
      return c;
    end
  endfunction

endpackage

// ===== sv/rax_req_if.sv =====
`timescale 1ns / 1ps
interface rax_req_if;
  import rax_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [FIELD_W-1:0] a_digits;
  logic               a_neg;
  logic               a_zero;
  logic [FIELD_W-1:0] b_digits;
  logic               b_neg;
  logic               b_zero;

  modport source (
    output valid, req_type, a_digits, a_neg, a_zero, b_digits, b_neg, b_zero,
    input  ready
  );

  modport sink (
    input  valid, req_type, a_digits, a_neg, a_zero, b_digits, b_neg, b_zero,
    output ready
  );
endinterface

// ===== sv/rax_rsp_if.sv =====
`timescale 1ns / 1ps
interface rax_rsp_if;
  import rax_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] sum_digits;
  logic               sum_neg;
  logic               sum_zero;
  logic               overflow;

  modport source (
    output valid, sum_digits, sum_neg, sum_zero, overflow,
    input  ready
  );

  modport sink (
    input  valid, sum_digits, sum_neg, sum_zero, overflow,
    output ready
  );
endinterface

// ===== sv/rax_lane.sv =====
`timescale 1ns / 1ps
module rax_lane (
  input  logic [rax_pkg::DIGIT_W-1:0] a_digit_i,
  input  logic [rax_pkg::DIGIT_W-1:0] b_digit_i,
  output rax_pkg::lane_cand_t         cand_o
);
  import rax_pkg::*;

  logic [NORM_W-1:0] a_ext;
  logic [NORM_W-1:0] b_ext;

  assign a_ext = NORM_W'(a_digit_i);
  assign b_ext = NORM_W'(b_digit_i);

  // Carry-select: every possible incoming carry is tried for a+b, a-b and b-a.
  always_comb begin
    for (int k = 0; k < NCARRY; k++) begin
      cand_o.add_c[k] = digit_norm(a_ext + b_ext + NORM_BIAS + NORM_W'(k));
      cand_o.ab_c[k]  = digit_norm(a_ext + NORM_BIAS + NORM_W'(k) - b_ext);
      cand_o.ba_c[k]  = digit_norm(b_ext + NORM_BIAS + NORM_W'(k) - a_ext);
    end
  end
endmodule

// ===== sv/rax_merge.sv =====
`timescale 1ns / 1ps
module rax_merge (
  input  rax_pkg::lane_cand_t [rax_pkg::DIGITS-1:0] cand_i,
  input  rax_pkg::sel_t                             sel_i,
  output rax_pkg::res_t                             res_o
);
  import rax_pkg::*;

  carry_t                          c_add;
  carry_t                          c_ab;
  carry_t                          c_ba;
  carry_t                          c_sel;
  logic [DIGITS-1:0][DIGIT_W-1:0]  r_add;
  logic [DIGITS-1:0][DIGIT_W-1:0]  r_ab;
  logic [DIGITS-1:0][DIGIT_W-1:0]  r_ba;
  logic [DIGITS-1:0][DIGIT_W-1:0]  r_sel;
  logic                            same;
  logic                            neg;

  // Resolve the carries lane by lane: a mux chain over the precomputed candidates.
  always_comb begin
    c_add = CARRY_ZERO;
    c_ab  = CARRY_ZERO;
    c_ba  = CARRY_ZERO;
    for (int k = 0; k < DIGITS; k++) begin
      r_add[k] = cand_i[k].add_c[c_add].digit;
      r_ab[k]  = cand_i[k].ab_c[c_ab].digit;
      r_ba[k]  = cand_i[k].ba_c[c_ba].digit;
      c_add    = cand_i[k].add_c[c_add].cout;
      c_ab     = cand_i[k].ab_c[c_ab].cout;
      c_ba     = cand_i[k].ba_c[c_ba].cout;
    end
  end

  // A zero operand is signless, so it always takes the adding path.
  assign same = (sel_i.sa == sel_i.sb) || sel_i.az || sel_i.bz;

  always_comb begin
    priority if (same) begin
      r_sel = r_add;
      c_sel = c_add;
      neg   = sel_i.az ? sel_i.sb : sel_i.sa;
    end else if (c_ab >= CARRY_ZERO) begin
      // a - b did not go below zero: |a| >= |b|
      r_sel = r_ab;
      c_sel = c_ab;
      neg   = sel_i.sa;
    end else begin
      r_sel = r_ba;
      c_sel = c_ba;
      neg   = sel_i.sb;
    end
  end

  always_comb begin
    res_o.digits = '0;
    for (int k = 0; k < DIGITS; k++) begin
      res_o.digits[k*DIGIT_W +: DIGIT_W] = r_sel[k];
    end
    res_o.zero = (r_sel == '0);
    res_o.neg  = neg && (r_sel != '0);
    res_o.ovf  = (c_sel != CARRY_ZERO);
  end
endmodule

// ===== sv/radix_1000_signed_add_sub.sv =====
`timescale 1ns / 1ps
// Sign-magnitude add/subtract of two radix-1000 numbers, six 10-bit digits each.
// req_i carries one operand pair and the operation (add, or a minus b); rsp_o
// returns one result per request: digits, sign, zero flag and overflow.
// Both channels use valid/ready; a transfer happens when both are high.
// rsp_o.valid rises once the item has passed the first-stage register and then
// the output register. Throughput is one item per cycle while the receiver does
// not stall: stage one runs a lane per digit that works out sum and
// both differences for every incoming carry, stage two resolves the carry chain
// and picks the path, into the output register.
// A zero-flagged operand counts as zero; an exact cancel gives positive zero.
// Carry out of the top digit sets overflow and the digits wrap.
// When the receiver stalls, the output register holds its result and the
// first stage keeps one more item; req_i.ready then drops until rsp_o drains.
// Reset (rst_ni low, asynchronous) empties both stages; no result is pending
// afterwards and a request may be sent in the first cycle after release.
module radix_1000_signed_add_sub (
  input  logic       clk_i,
  input  logic       rst_ni,
  rax_req_if.sink    req_i,
  rax_rsp_if.source  rsp_o
);
  import rax_pkg::*;

  logic                            sa;
  logic                            sb;
  logic                            a_nil;
  logic                            b_nil;
  sel_t                            sel_d;
  lane_cand_t [DIGITS-1:0]         cand_d;
  logic [DIGITS-1:0][DIGIT_W-1:0]  a_dig;
  logic [DIGITS-1:0][DIGIT_W-1:0]  b_dig;

  logic                            s1_valid_q;
  sel_t                            s1_sel_q;
  lane_cand_t [DIGITS-1:0]         s1_cand_q;
  res_t                            res_d;
  res_t                            res_q;
  logic                            out_valid_q;

  logic                            out_free;
  logic                            in_xfer;
  logic                            s1_move;

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      a_dig[k] = req_i.a_zero ? '0 : req_i.a_digits[k*DIGIT_W +: DIGIT_W];
      b_dig[k] = req_i.b_zero ? '0 : req_i.b_digits[k*DIGIT_W +: DIGIT_W];
    end
  end

  assign sa    = req_i.a_neg;
  assign sb    = req_i.b_neg ^ req_i.req_type;
  assign a_nil = (a_dig == '0);
  assign b_nil = (b_dig == '0);

  assign sel_d = '{sa: sa, sb: sb, az: a_nil, bz: b_nil};

  for (genvar g = 0; g < DIGITS; g++) begin : g_lane
    rax_lane u_lane (
      .a_digit_i (a_dig[g]),
      .b_digit_i (b_dig[g]),
      .cand_o    (cand_d[g])
    );
  end

  rax_merge u_merge (
    .cand_i (s1_cand_q),
    .sel_i  (s1_sel_q),
    .res_o  (res_d)
  );

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_move     = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign in_xfer     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sel_q  <= sel_d;
      s1_cand_q <= cand_d;
    end
    if (s1_move) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.sum_digits = res_q.digits;
  assign rsp_o.sum_neg    = res_q.neg;
  assign rsp_o.sum_zero   = res_q.zero;
  assign rsp_o.overflow   = res_q.ovf;

`ifndef SYNTH
  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.zero && res_q.neg))
    else $error("negative zero on response");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.zero == (res_q.digits == '0)))
    else $error("zero flag disagrees with digits");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_sel_q)))
    else $error("first stage lost an item under stall");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.digits[DIGIT_W-1:0] <= DIGIT_W'(DIGIT_MAX)))
    else $error("low result digit out of range");
`endif

endmodule

// ===== dv/tb_radix_1000_signed_add_sub.sv =====
`timescale 1ns / 1ps
module tb_radix_1000_signed_add_sub;
  import rax_pkg::*;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  localparam logic [FIELD_W-1:0] ALL_999  = {6{10'd999}};
  localparam logic [FIELD_W-1:0] ALL_1023 = {6{10'h3FF}};
  localparam longint unsigned    MODULUS  = 64'd1000000000000000000;

  localparam int DIR_N      = 18;
  localparam int RAND_N     = 1500;
  localparam int TOTAL_N    = DIR_N + RAND_N;
  localparam int CALM_N     = 200;   // last items run with no idling
  localparam int HOLD_AT    = 300;
  localparam int HOLD_CYC   = 80;
  localparam int WATCHDOG   = 2000;
  localparam int DRAIN_CYC  = 8;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] a_digits;
    logic               a_neg;
    logic               a_zero;
    logic [FIELD_W-1:0] b_digits;
    logic               b_neg;
    logic               b_zero;
    logic               fixed_exp;
    res_t               exp;
  } stim_t;

  logic clk_i;
  logic rst_ni;

  rax_req_if req_bus ();
  rax_rsp_if rsp_bus ();

  radix_1000_signed_add_sub dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  res_t        sum_q [$];
  int          sent_cnt;
  int          fail_cnt;
  int          quiet_cyc;
  logic        hold_done;
  stim_t       dir_tbl [DIR_N];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned digits_value(input logic [FIELD_W-1:0] d);
    longint unsigned v;
    begin
      v = 0;
      for (int k = DIGITS - 1; k >= 0; k--) begin
        v = v * RADIX + d[k*DIGIT_W +: DIGIT_W];
      end
      return v;
    end
  endfunction

  function automatic res_t predict_sum(input stim_t s);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned mag;
    logic            sa;
    logic            sb;
    logic            neg;
    res_t            r;
    begin
      sa = s.a_neg;
      sb = s.b_neg ^ (s.req_type == OP_SUB);
      ma = s.a_zero ? 0 : digits_value(s.a_digits);
      mb = s.b_zero ? 0 : digits_value(s.b_digits);
      // a zero operand carries no sign
      if (ma == 0) sa = sb;
      if (mb == 0) sb = sa;
      if (sa == sb) begin
        mag = ma + mb;
        neg = sa;
      end else if (ma >= mb) begin
        mag = ma - mb;
        neg = sa;
      end else begin
        mag = mb - ma;
        neg = sb;
      end
      r.ovf = (mag >= MODULUS);
      mag   = mag % MODULUS;
      r.zero = (mag == 0);
      r.neg  = neg && (mag != 0);
      r.digits = '0;
      for (int k = 0; k < DIGITS; k++) begin
        r.digits[k*DIGIT_W +: DIGIT_W] = DIGIT_W'(mag % RADIX);
        mag = mag / RADIX;
      end
      return r;
    end
  endfunction

  function automatic logic [FIELD_W-1:0] random_digits();
    logic [FIELD_W-1:0] d;
    int unsigned        top;
    begin
      d   = '0;
      top = $urandom_range(0, DIGITS - 1);
      case ($urandom_range(0, 9))
        0: d = '0;
        1: d = ALL_999;
        2: d = FIELD_W'({$urandom, $urandom});
        3: begin
          for (int k = 0; k < DIGITS; k++) begin
            d[k*DIGIT_W +: DIGIT_W] = $urandom_range(0, 1) ? DIGIT_W'(DIGIT_MAX) : '0;
          end
        end
        4: begin
          for (int k = 0; k <= int'(top); k++) begin
            d[k*DIGIT_W +: DIGIT_W] = DIGIT_W'($urandom_range(0, DIGIT_MAX));
          end
        end
        default: begin
          for (int k = 0; k < DIGITS; k++) begin
            d[k*DIGIT_W +: DIGIT_W] = DIGIT_W'($urandom_range(0, DIGIT_MAX));
          end
        end
      endcase
      return d;
    end
  endfunction

  function automatic stim_t random_pair();
    stim_t s;
    begin
      s.req_type = $urandom_range(0, 1) ? OP_SUB : OP_ADD;
      s.a_digits = random_digits();
      s.b_digits = ($urandom_range(0, 7) == 0) ? s.a_digits : random_digits();
      s.a_neg    = 1'($urandom_range(0, 1));
      s.b_neg    = 1'($urandom_range(0, 1));
      s.a_zero   = ($urandom_range(0, 9) == 0);
      s.b_zero   = ($urandom_range(0, 9) == 0);
      s.fixed_exp = 1'b0;
      s.exp       = '0;
      return s;
    end
  endfunction

  // one transfer on the request side; valid stays high between back-to-back items
  task automatic send_pair(input stim_t s);
    int gap;
    begin
      if (sent_cnt < TOTAL_N - CALM_N && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 9);
        req_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= s.req_type;
      req_bus.a_digits <= s.a_digits;
      req_bus.a_neg    <= s.a_neg;
      req_bus.a_zero   <= s.a_zero;
      req_bus.b_digits <= s.b_digits;
      req_bus.b_neg    <= s.b_neg;
      req_bus.b_zero   <= s.b_zero;
      do @(posedge clk_i); while (!req_bus.ready);
      sum_q.push_back(s.fixed_exp ? s.exp : predict_sum(s));
      sent_cnt++;
      @(negedge clk_i);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = OP_ADD;
    req_bus.a_digits = '0;
    req_bus.a_neg    = 1'b0;
    req_bus.a_zero   = 1'b0;
    req_bus.b_digits = '0;
    req_bus.b_neg    = 1'b0;
    req_bus.b_zero   = 1'b0;
    sent_cnt         = 0;
    fail_cnt         = 0;

    dir_tbl = '{
      // both operands flagged zero
      '{OP_ADD, '0, 1'b0, 1'b1, '0, 1'b0, 1'b1, 1'b1, '{'0, 1'b0, 1'b1, 1'b0}},
      // top value plus one wraps to zero
      '{OP_ADD, ALL_999, 1'b0, 1'b0, 60'd1, 1'b0, 1'b0, 1'b1, '{'0, 1'b0, 1'b1, 1'b1}},
      '{OP_ADD, ALL_999, 1'b1, 1'b0, 60'd1, 1'b1, 1'b0, 1'b1, '{'0, 1'b0, 1'b1, 1'b1}},
      '{OP_SUB, ALL_999, 1'b0, 1'b0, ALL_999, 1'b1, 1'b0, 1'b0, '0},
      // exact cancels
      '{OP_SUB, 60'd123, 1'b1, 1'b0, 60'd123, 1'b1, 1'b0, 1'b1, '{'0, 1'b0, 1'b1, 1'b0}},
      '{OP_ADD, 60'd123, 1'b0, 1'b0, 60'd123, 1'b1, 1'b0, 1'b1, '{'0, 1'b0, 1'b1, 1'b0}},
      // flagged zero ignores digits and sign
      '{OP_SUB, ALL_1023, 1'b1, 1'b1, 60'd5, 1'b0, 1'b0, 1'b1, '{60'd5, 1'b1, 1'b0, 1'b0}},
      '{OP_ADD, 60'd7, 1'b1, 1'b0, ALL_1023, 1'b0, 1'b1, 1'b1, '{60'd7, 1'b1, 1'b0, 1'b0}},
      // zero operands with a sign, unflagged and flagged
      '{OP_ADD, '0, 1'b1, 1'b0, 60'd7, 1'b0, 1'b0, 1'b1, '{60'd7, 1'b0, 1'b0, 1'b0}},
      '{OP_SUB, 60'd7, 1'b0, 1'b0, '0, 1'b1, 1'b0, 1'b1, '{60'd7, 1'b0, 1'b0, 1'b0}},
      '{OP_ADD, ALL_1023, 1'b1, 1'b1, ALL_1023, 1'b1, 1'b1, 1'b1, '{'0, 1'b0, 1'b1, 1'b0}},
      // digits above 999 at face value
      '{OP_ADD, ALL_1023, 1'b0, 1'b0, ALL_1023, 1'b0, 1'b0, 1'b0, '0},
      '{OP_SUB, ALL_1023, 1'b0, 1'b0, ALL_999, 1'b0, 1'b0, 1'b0, '0},
      '{OP_SUB, ALL_1023, 1'b1, 1'b0, ALL_1023, 1'b0, 1'b0, 1'b0, '0},
      // borrow across zero digits
      '{OP_SUB, 60'd1 << 50, 1'b0, 1'b0, 60'd1, 1'b0, 1'b0, 1'b0, '0},
      '{OP_ADD, 60'd1, 1'b0, 1'b0, ALL_999, 1'b1, 1'b0, 1'b0, '0},
      '{OP_ADD, 60'h3FF << 50, 1'b0, 1'b0, 60'h3E7 << 50, 1'b0, 1'b0, 1'b0, '0},
      '{OP_SUB, 60'h0123456789ABCDE, 1'b1, 1'b0, 60'h0FEDCBA98765432, 1'b0, 1'b0, 1'b0, '0}
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      send_pair(dir_tbl[i]);
    end
    for (int i = 0; i < RAND_N; i++) begin
      send_pair(random_pair());
    end
    req_bus.valid <= 1'b0;

    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the pipe up
  initial begin
    rsp_bus.ready = 1'b0;
    hold_done     = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
      end else if (sent_cnt < TOTAL_N - CALM_N && $urandom_range(0, 4) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (sum_q.size() == 0) begin
        $error("unexpected result transfer: digits %h", rsp_bus.sum_digits);
        fail_cnt++;
      end else begin
        automatic res_t want = sum_q.pop_front();
        if (rsp_bus.sum_digits !== want.digits) begin
          $error("sum_digits: expected %h, got %h", want.digits, rsp_bus.sum_digits);
          fail_cnt++;
        end
        if (rsp_bus.sum_neg !== want.neg) begin
          $error("sum_neg: expected %b, got %b", want.neg, rsp_bus.sum_neg);
          fail_cnt++;
        end
        if (rsp_bus.sum_zero !== want.zero) begin
          $error("sum_zero: expected %b, got %b", want.zero, rsp_bus.sum_zero);
          fail_cnt++;
        end
        if (rsp_bus.overflow !== want.ovf) begin
          $error("overflow: expected %b, got %b", want.ovf, rsp_bus.overflow);
          fail_cnt++;
        end
      end
    end
  end

  // no transfer on either side for too long ends the run
  initial begin
    quiet_cyc = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        quiet_cyc = 0;
      end else begin
        quiet_cyc++;
      end
      if (quiet_cyc >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
